// File: design/assert_macros.svh
// assertion helpers for the partition scatter block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`endif

// File: design/mkps_pkg.sv
`timescale 1ns / 1ps
package mkps_pkg;
  localparam int unsigned MaxPartitionsDef = 64;
  localparam int unsigned SlotsPerPartitionDef = 65536;
  localparam int unsigned NumPartW = 7;
  localparam int unsigned KeyW = 64;
  localparam int unsigned IdxW = 32;
  localparam int unsigned PartW = 6;
  localparam int unsigned SlotW = 16;
  localparam int unsigned StatW = 2;

  typedef enum logic [StatW-1:0] {
    ST_OK   = 2'd0,
    ST_NEG  = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    DIV_IDLE = 3'b001,
    DIV_RUN  = 3'b010,
    DIV_DONE = 3'b100
  } div_state_e;

  typedef enum logic [2:0] {
    BK_CLEAR = 3'b001,
    BK_IDLE  = 3'b010,
    BK_LOOK  = 3'b100
  } back_state_e;
endpackage

// File: design/mkps_if.sv
`timescale 1ns / 1ps
interface mkps_in_if import mkps_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [KeyW-1:0] key;
  logic [IdxW-1:0] companion_index;
  logic            last_in_batch;
  modport source (output valid, key, companion_index, last_in_batch, input ready);
  modport sink (input valid, key, companion_index, last_in_batch, output ready);
endinterface

interface mkps_out_if import mkps_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PartW-1:0] partition;
  logic [SlotW-1:0] slot;
  logic [KeyW-1:0]  key_out;
  logic [IdxW-1:0]  index_out;
  logic [StatW-1:0] status;
  logic             batch_end;
  modport source (output valid, partition, slot, key_out, index_out, status, batch_end,
                  input ready);
  modport sink (input valid, partition, slot, key_out, index_out, status, batch_end,
                output ready);
endinterface

// File: design/mkps_front.sv
`timescale 1ns / 1ps
// restoring bit-serial remainder of |key| by the divisor, one bit per cycle
module mkps_front import mkps_pkg::*; #(
  parameter int unsigned MaxPartitions = MaxPartitionsDef,
  localparam int unsigned PW = $clog2(MaxPartitions),
  localparam int unsigned RW = PW + 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [NumPartW-1:0] npart_i,
  mkps_in_if.sink           in_if,
  output logic              fv_o,
  input  logic              fr_i,
  output logic [PW-1:0]     fpart_o,
  output logic              fneg_o,
  output logic [KeyW-1:0]   fkey_o,
  output logic [IdxW-1:0]   fidx_o,
  output logic              flast_o
);
  localparam int unsigned CntW = $clog2(KeyW);
  localparam int unsigned DW = (NumPartW > RW) ? NumPartW : RW;

  div_state_e          state_q, state_d;
  logic [KeyW-1:0]     mag_q, key_q;
  logic [IdxW-1:0]     idx_q;
  logic                last_q;
  logic [RW-1:0]       rem_q;
  logic [RW-1:0]       div_q;
  logic [CntW-1:0]     cnt_q;
  logic [DW-1:0]       n_w;
  logic [RW:0]         sh;
  logic [RW:0]         df;
  logic                rem_nz;

  always_comb begin
    n_w = DW'(npart_i);
    if (n_w == '0) n_w = DW'(1);
    if (n_w > DW'(MaxPartitions)) n_w = DW'(MaxPartitions);
  end

  assign sh = {rem_q, mag_q[KeyW-1]};
  assign df = sh - {1'b0, div_q};
  assign rem_nz = rem_q != '0;

  assign in_if.ready = state_q == DIV_IDLE;
  assign fv_o = state_q == DIV_DONE;
  assign fneg_o = key_q[KeyW-1] && rem_nz;
  assign fpart_o = fneg_o ? '0 : rem_q[PW-1:0];
  assign fkey_o = key_q;
  assign fidx_o = idx_q;
  assign flast_o = last_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DIV_IDLE: if (in_if.valid) state_d = DIV_RUN;
      DIV_RUN:  if (cnt_q == CntW'(KeyW - 1)) state_d = DIV_DONE;
      DIV_DONE: if (fr_i) state_d = DIV_IDLE;
      default:  state_d = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == DIV_RUN) cnt_q <= cnt_q + 1'b1;
      else cnt_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == DIV_IDLE && in_if.valid) begin
      key_q <= in_if.key;
      idx_q <= in_if.companion_index;
      last_q <= in_if.last_in_batch;
      mag_q <= in_if.key[KeyW-1] ? (~in_if.key + 1'b1) : in_if.key;
      rem_q <= '0;
      div_q <= RW'(n_w);
    end else if (state_q == DIV_RUN) begin
      mag_q <= {mag_q[KeyW-2:0], 1'b0};
      rem_q <= df[RW] ? sh[RW-1:0] : df[RW-1:0];
    end
  end
endmodule

// File: design/mkps_back.sv
`timescale 1ns / 1ps
// simple dual-port ram, registered read
module ram_1r1w #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  assign rdata_o = rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end
endmodule

// count table update and output register
module mkps_back import mkps_pkg::*; #(
  parameter int unsigned MaxPartitions = MaxPartitionsDef,
  parameter int unsigned SlotsPerPartition = SlotsPerPartitionDef,
  localparam int unsigned PW = $clog2(MaxPartitions),
  localparam int unsigned CW = $clog2(SlotsPerPartition) + 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fv_i,
  output logic            fr_o,
  input  logic [PW-1:0]   fpart_i,
  input  logic            fneg_i,
  input  logic [KeyW-1:0] fkey_i,
  input  logic [IdxW-1:0] fidx_i,
  input  logic            flast_i,
  mkps_out_if.source      out_if
);
  back_state_e   state_q, state_d;
  logic [PW-1:0] clr_addr_q;
  logic [PW-1:0] part_q;
  logic          neg_q, last_q;
  logic          vld_q;
  logic [CW-1:0] c;
  logic          full, take;
  logic          ram_we;
  logic [PW-1:0] ram_waddr;
  logic [CW-1:0] ram_wdata;

  // count read is issued at the hand-off, data arrives in the look cycle
  ram_1r1w #(.Width(CW), .Depth(MaxPartitions)) u_cnt_ram (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(ram_wdata),
    .raddr_i(fpart_i), .rdata_o(c)
  );

  assign full = c >= CW'(SlotsPerPartition);
  assign fr_o = (state_q == BK_IDLE) && !vld_q;
  assign take = fv_i && fr_o;
  assign out_if.valid = vld_q;

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = part_q;
    ram_wdata = c + 1'b1;
    if (state_q == BK_CLEAR) begin
      ram_we = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else if (state_q == BK_LOOK && !neg_q && !full) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_CLEAR: if (clr_addr_q == PW'(MaxPartitions - 1)) state_d = BK_IDLE;
      BK_IDLE:  if (take) state_d = BK_LOOK;
      BK_LOOK:  state_d = last_q ? BK_CLEAR : BK_IDLE;
      default:  state_d = BK_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_CLEAR;
      clr_addr_q <= '0;
      vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == BK_CLEAR) begin
        clr_addr_q <= (state_d == BK_CLEAR) ? clr_addr_q + 1'b1 : '0;
      end
      if (state_q == BK_LOOK) vld_q <= 1'b1;
      else if (out_if.ready) vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      part_q <= fpart_i;
      neg_q <= fneg_i;
      last_q <= flast_i;
      out_if.key_out <= fkey_i;
      out_if.index_out <= fidx_i;
      out_if.batch_end <= flast_i;
      out_if.partition <= PartW'(fpart_i);
    end
    if (state_q == BK_LOOK) begin
      if (neg_q) begin
        out_if.slot <= '0;
        out_if.status <= ST_NEG;
      end else if (full) begin
        out_if.slot <= SlotW'(SlotsPerPartition - 1);
        out_if.status <= ST_FULL;
      end else begin
        out_if.slot <= SlotW'(c);
        out_if.status <= ST_OK;
      end
    end
  end
endmodule

// File: design/modulo_key_partition_scatter.sv
`timescale 1ns / 1ps
// Partition scatter: each key beat gets partition = key % divisor (C truncating
// remainder) and the next free slot of that partition, with key and index passed
// through. The front computes the remainder with a one-bit-per-cycle restoring divider
// over the 64-bit key magnitude, then hands it to the back, which reads the count
// memory, updates it and loads the output register. The front accepts no new key until
// it has handed the last one to the back; it starts the next key while a result waits,
// and stalls in its done state while the output register is still full or the back is
// clearing. A negative nonzero remainder gives status 1; a full partition gives status
// 2 and a saturated slot. All counts clear after a beat marked last_in_batch: the back
// runs a clearing pass over every entry of the count memory, also after reset.
// Write the divisor register only while the block is idle.
`include "assert_macros.svh"
module modulo_key_partition_scatter import mkps_pkg::*; #(
  parameter int unsigned MaxPartitions = MaxPartitionsDef,
  parameter int unsigned SlotsPerPartition = SlotsPerPartitionDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [NumPartW-1:0] cfg_wdata_i,
  mkps_in_if.sink             in_if,
  mkps_out_if.source          out_if
);
  localparam int unsigned PW = $clog2(MaxPartitions);

  logic [NumPartW-1:0] num_part_q;
  // front to back hand-off
  logic            fv, fr, fneg, flast;
  logic [PW-1:0]   fpart;
  logic [KeyW-1:0] fkey;
  logic [IdxW-1:0] fidx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) num_part_q <= NumPartW'(1);
    else if (cfg_we_i) num_part_q <= cfg_wdata_i;
  end

  mkps_front #(.MaxPartitions(MaxPartitions)) u_front (
    .clk_i, .rst_ni, .npart_i(num_part_q), .in_if,
    .fv_o(fv), .fr_i(fr), .fpart_o(fpart), .fneg_o(fneg),
    .fkey_o(fkey), .fidx_o(fidx), .flast_o(flast)
  );

  mkps_back #(.MaxPartitions(MaxPartitions), .SlotsPerPartition(SlotsPerPartition)) u_back (
    .clk_i, .rst_ni, .fv_i(fv), .fr_o(fr), .fpart_i(fpart), .fneg_i(fneg),
    .fkey_i(fkey), .fidx_i(fidx), .flast_i(flast), .out_if
  );

  // a negative status never reports a partition or slot
  `ASSERT_CLK(a_neg_zero, clk_i, rst_ni,
    out_if.valid && out_if.status == ST_NEG |-> out_if.partition == '0 && out_if.slot == '0,
    "negative status with nonzero fields")
  // status code stays within the defined set
  `ASSERT_CLK(a_stat, clk_i, rst_ni, out_if.valid |-> out_if.status != 2'd3, "bad status")
  // a held result stays valid and keeps its slot while stalled
  `ASSERT_CLK(a_hold, clk_i, rst_ni,
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.slot),
    "result changed under stall")
endmodule
